[rtl/ddc_pkg.sv]
// Shared constants and types for the differential-drive distance controller.
`default_nettype none
package ddc_pkg;
  localparam logic [1:0] OP_SAMPLE   = 2'd0;
  localparam logic [1:0] OP_STRAIGHT = 2'd1;
  localparam logic [1:0] OP_ARC      = 2'd2;

  localparam logic [1:0] CFG_HALF_TRACK = 2'd0;
  localparam logic [1:0] CFG_PERIOD     = 2'd1;
  localparam logic [1:0] CFG_TRIM       = 2'd2;

  // pi/180 in Q32 = 0x477D1A9, split into two multiplier operands
  localparam logic signed [16:0] DEG_RAD_LO = 17'sd53673;
  localparam logic signed [16:0] DEG_RAD_HI = 17'sd1143;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_STRAIGHT = 2'd1,
    MODE_ARC      = 2'd2
  } mode_t;
endpackage
`default_nettype wire

[rtl/diff_drive_distance_controller.sv]
// Differential-drive distance controller: straight and arc moves for two wheels.
//
//  port group  | dir | contents
//  in_*        | in  | tuser: opcode; tdata: wheel speeds, move and arc fields
//  out_*       | out | tdata: left_drive, right_drive, movement_done
//  cfg_*       | in  | register write: half track, sample period, trim step
//
// Straight start goes directly to emit; a speed sample steps CMPM (arc only), ADVL, ADVR, ADVF
// and FIN. Arc start runs AL0-AL3 for each wheel, then the 64-step restoring ratio divider
// (skipped when the right arc distance is zero); all products go through one shared 36x17
// multiplier. Synchronous active-low reset returns to idle with cleared move state and
// default configuration. A finished word waits in the output register; a new word is taken meanwhile.
`default_nettype none
module diff_drive_distance_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // opcode
  // [15:0] left_wheel_speed, [31:16] right_wheel_speed, [46:32] move_speed,
  // [62:47] move_distance, [78:63] arc_radius, [91:79] arc_degrees, rest zero
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] left_drive, [31:16] right_drive, [32] movement_done, rest zero
  output logic [39:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [23:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMPM, S_ADVL, S_ADVR, S_ADVF, S_FIN,
    S_AL0, S_AL1, S_AL2, S_AL3, S_ASET, S_DIV, S_DRV, S_DRV2, S_EMIT
  } state_t;

  localparam logic signed [47:0] REM_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] REM_MIN = {1'b1, {47{1'b0}}};

  state_t state_r;
  ddc_pkg::mode_t mode_r;
  logic [15:0] half_track_r;
  logic [23:0] period_r;
  logic [7:0]  trim_r;

  logic signed [15:0] ls_r, rs_r, rad_r;
  logic [14:0]        spd_r;
  logic signed [12:0] deg_r;

  logic signed [47:0] lrem_r, rrem_r, la_r, ra_r;
  logic signed [15:0] lcmd_r, rcmd_r;
  logic ldir_r, rdir_r, sdir_r;
  logic signed [31:0] ratio_r;

  logic signed [52:0] prod_r;
  logic signed [35:0] p_r;
  logic signed [63:0] acc_r;
  logic               side_r;
  logic [47:0]        rem_r;
  logic [47:0]        dvs_r;
  logic [63:0]        dq_r;
  logic [5:0]         cnt_r;

  logic signed [15:0] res_ld_r, res_rd_r;
  logic               res_done_r;
  logic               out_valid_r;
  logic [39:0]        out_data_r;

  // shared multiplier
  logic signed [35:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [52:0] mul_p;
  logic signed [21:0] lever;

  always_comb begin
    lever = side_r ? ({{2{rad_r[15]}}, rad_r, 4'b0} - $signed({6'b0, half_track_r}))
                   : ({{2{rad_r[15]}}, rad_r, 4'b0} + $signed({6'b0, half_track_r}));
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_CMPM: begin
        mul_a = 36'(ratio_r);
        mul_b = 17'(rs_r);
      end
      S_ADVL: begin
        mul_a = $signed({12'b0, period_r});
        mul_b = 17'(ls_r);
      end
      S_ADVR: begin
        mul_a = $signed({12'b0, period_r});
        mul_b = 17'(rs_r);
      end
      S_AL0: begin
        mul_a = 36'(lever);
        mul_b = 17'(deg_r);
      end
      S_AL1: begin
        mul_a = prod_r[35:0];
        mul_b = ddc_pkg::DEG_RAD_LO;
      end
      S_AL2: begin
        mul_a = p_r;
        mul_b = ddc_pkg::DEG_RAD_HI;
      end
      S_DRV: begin
        mul_a = $signed({21'b0, spd_r});
        mul_b = $signed({2'b0, spd_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 53'(mul_a) * 53'(mul_b);
  end

  function automatic logic signed [15:0] sat_add(logic signed [15:0] c,
                                                 logic signed [8:0] d);
    logic signed [16:0] s;
    s = 17'(c) + 17'(d);
    if (s > 17'sd32767) return 16'sd32767;
    if (s < -17'sd32768) return -16'sd32768;
    return s[15:0];
  endfunction

  function automatic logic signed [47:0] advance(logic signed [47:0] rem,
                                                 logic signed [52:0] p);
    logic signed [49:0] s;
    s = 50'(rem) - 50'(p >>> 4);
    if (s > 50'(REM_MAX)) return REM_MAX;
    if (s < 50'(REM_MIN)) return REM_MIN;
    return s[47:0];
  endfunction

  function automatic logic crossed(logic signed [47:0] rem, logic back);
    return (rem < 0 && !back) || (rem > 0 && back);
  endfunction

  logic signed [8:0]  step;
  logic signed [49:0] cmp_a, cmp_b;
  logic signed [63:0] arc_acc;
  logic signed [47:0] arc_len, l_sel, r_sel;
  logic [48:0]        trial;
  logic signed [15:0] cross_l, cross_r;
  logic [29:0]        sq;
  logic signed [15:0] outer_cmd, inner_l, inner_r;
  logic signed [15:0] st_cmd;
  logic signed [31:0] ratio_div;

  always_comb begin
    step = $signed({1'b0, trim_r});
    cmp_a = 50'($signed({ls_r, 16'b0}));
    cmp_b = 50'(prod_r);
    if (rs_r < 0) begin
      cmp_a = -cmp_a;
      cmp_b = -cmp_b;
    end
    arc_acc = acc_r + (64'(prod_r) <<< 16);
    arc_len = arc_acc[59:12];
    l_sel = (deg_r < 0) ? -ra_r : la_r;
    r_sel = (deg_r < 0) ? -la_r : ra_r;
    trial = {rem_r, dq_r[63]} - {1'b0, dvs_r};
    cross_l = crossed(lrem_r, (mode_r == ddc_pkg::MODE_ARC) ? ldir_r : sdir_r) ? '0 : lcmd_r;
    cross_r = crossed(rrem_r, (mode_r == ddc_pkg::MODE_ARC) ? rdir_r : sdir_r) ? '0 : rcmd_r;
    sq = prod_r[29:0];
    outer_cmd = (sq > 30'd32767) ? 16'sd32767 : $signed(sq[15:0]);
    inner_l = ldir_r ? -$signed({1'b0, spd_r}) : $signed({1'b0, spd_r});
    inner_r = rdir_r ? -$signed({1'b0, spd_r}) : $signed({1'b0, spd_r});
    st_cmd = (in_tdata[62:47] == 16'd0 || in_tdata[62]) ? -$signed({1'b0, in_tdata[46:32]})
                                                         : $signed({1'b0, in_tdata[46:32]});
    if (la_r[47] ^ ra_r[47])
      ratio_div = (dq_r > 64'h8000_0000) ? 32'sh8000_0000 : -$signed(dq_r[31:0]);
    else
      ratio_div = (dq_r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(dq_r[31:0]);
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r <= ddc_pkg::MODE_IDLE;
      half_track_r <= 16'd680;
      period_r <= 24'd80660;
      trim_r <= 8'd1;
      lrem_r <= '0;
      rrem_r <= '0;
      lcmd_r <= '0;
      rcmd_r <= '0;
      ldir_r <= 1'b0;
      rdir_r <= 1'b0;
      sdir_r <= 1'b0;
      ratio_r <= '0;
      out_valid_r <= 1'b0;
      side_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ddc_pkg::CFG_HALF_TRACK: half_track_r <= cfg_wdata[15:0];
          ddc_pkg::CFG_PERIOD:     period_r <= cfg_wdata;
          ddc_pkg::CFG_TRIM:       trim_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (out_tready && state_r != S_EMIT) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ls_r  <= in_tdata[15:0];
            rs_r  <= in_tdata[31:16];
            spd_r <= in_tdata[46:32];
            rad_r <= in_tdata[78:63];
            deg_r <= in_tdata[91:79];
            side_r <= 1'b0;
            case (in_tuser)
              ddc_pkg::OP_STRAIGHT: begin
                sdir_r <= (in_tdata[62:47] == 16'd0 || in_tdata[62]);
                lcmd_r <= st_cmd;
                rcmd_r <= st_cmd;
                lrem_r <= {{8{in_tdata[62]}}, in_tdata[62:47], 24'b0};
                rrem_r <= {{8{in_tdata[62]}}, in_tdata[62:47], 24'b0};
                mode_r <= ddc_pkg::MODE_STRAIGHT;
                res_ld_r <= st_cmd;
                res_rd_r <= st_cmd;
                res_done_r <= 1'b0;
                state_r <= S_EMIT;
              end
              ddc_pkg::OP_ARC: begin
                if (in_tdata[91:79] != 13'd0) state_r <= S_AL0;
              end
              ddc_pkg::OP_SAMPLE: begin
                case (mode_r)
                  ddc_pkg::MODE_STRAIGHT: begin
                    if ($signed(in_tdata[15:0]) > $signed(in_tdata[31:16]))
                      lcmd_r <= sat_add(lcmd_r, -step);
                    else if ($signed(in_tdata[15:0]) < $signed(in_tdata[31:16]))
                      lcmd_r <= sat_add(lcmd_r, step);
                    state_r <= S_ADVL;
                  end
                  ddc_pkg::MODE_ARC: state_r <= S_CMPM;
                  default: begin
                    res_ld_r <= '0;
                    res_rd_r <= '0;
                    res_done_r <= 1'b1;
                    state_r <= S_EMIT;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        S_CMPM: state_r <= S_ADVL;
        S_ADVL: begin
          if (mode_r == ddc_pkg::MODE_ARC) begin
            if ((rs_r == 0) ? (ls_r > 0) : (cmp_a > cmp_b)) begin
              lcmd_r <= sat_add(lcmd_r, -step);
              rcmd_r <= sat_add(rcmd_r, step);
            end else if ((rs_r == 0) ? (ls_r < 0) : (cmp_a < cmp_b)) begin
              lcmd_r <= sat_add(lcmd_r, step);
              rcmd_r <= sat_add(rcmd_r, -step);
            end
          end
          state_r <= S_ADVR;
        end
        S_ADVR: begin
          lrem_r <= advance(lrem_r, prod_r);
          state_r <= S_ADVF;
        end
        S_ADVF: begin
          rrem_r <= advance(rrem_r, prod_r);
          state_r <= S_FIN;
        end
        S_FIN: begin
          lcmd_r <= cross_l;
          rcmd_r <= cross_r;
          res_ld_r <= cross_l;
          res_rd_r <= cross_r;
          res_done_r <= (cross_l == 0 && cross_r == 0);
          if (cross_l == 0 && cross_r == 0) mode_r <= ddc_pkg::MODE_IDLE;
          state_r <= S_EMIT;
        end
        S_AL0: state_r <= S_AL1;
        S_AL1: begin
          p_r <= prod_r[35:0];
          state_r <= S_AL2;
        end
        S_AL2: begin
          acc_r <= 64'(prod_r) + 64'sd2048;
          state_r <= S_AL3;
        end
        S_AL3: begin
          if (!side_r) begin
            la_r <= arc_len;
            side_r <= 1'b1;
            state_r <= S_AL0;
          end else begin
            ra_r <= arc_len;
            state_r <= S_ASET;
          end
        end
        S_ASET: begin
          la_r <= l_sel;
          ra_r <= r_sel;
          lrem_r <= l_sel;
          rrem_r <= r_sel;
          ldir_r <= !(deg_r > 0 || l_sel > 0);
          rdir_r <= !(deg_r < 0 || r_sel > 0);
          dq_r <= {(l_sel[47] ? -l_sel : l_sel), 16'b0};
          dvs_r <= r_sel[47] ? -r_sel : r_sel;
          rem_r <= '0;
          cnt_r <= '0;
          state_r <= (r_sel == 0) ? S_DRV : S_DIV;
        end
        S_DIV: begin
          if (!trial[48]) begin
            rem_r <= trial[47:0];
            dq_r <= {dq_r[62:0], 1'b1};
          end else begin
            rem_r <= {rem_r[46:0], dq_r[63]};
            dq_r <= {dq_r[62:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd63) state_r <= S_DRV;
        end
        S_DRV: begin
          if (ra_r == 0)
            ratio_r <= (la_r > 0) ? 32'sh7FFF_FFFF : ((la_r < 0) ? 32'sh8000_0000 : '0);
          else
            ratio_r <= ratio_div;
          state_r <= S_DRV2;
        end
        S_DRV2: begin
          if (deg_r > 0) begin
            lcmd_r <= ldir_r ? ((sq > 30'd32768) ? -16'sd32768 : -outer_cmd) : outer_cmd;
            res_ld_r <= ldir_r ? ((sq > 30'd32768) ? -16'sd32768 : -outer_cmd) : outer_cmd;
            rcmd_r <= inner_r;
            res_rd_r <= inner_r;
          end else begin
            rcmd_r <= rdir_r ? ((sq > 30'd32768) ? -16'sd32768 : -outer_cmd) : outer_cmd;
            res_rd_r <= rdir_r ? ((sq > 30'd32768) ? -16'sd32768 : -outer_cmd) : outer_cmd;
            lcmd_r <= inner_l;
            res_ld_r <= inner_l;
          end
          res_done_r <= 1'b0;
          mode_r <= ddc_pkg::MODE_ARC;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r <= {7'b0, res_done_r, res_rd_r, res_ld_r};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_done_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (res_done_r == (mode_r == ddc_pkg::MODE_IDLE)))
    else $error("done flag disagrees with mode");
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_DRV))
    else $error("divider left early");
  a_straight_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == ddc_pkg::OP_STRAIGHT) |=> (lcmd_r == rcmd_r))
    else $error("straight start drives differ");

endmodule
`default_nettype wire
